[design/nibble_table_hash_bucket_macros.svh]
// assertion macros shared by the hash bucket design
`ifndef NIBBLE_TABLE_HASH_BUCKET_MACROS_SVH
`define NIBBLE_TABLE_HASH_BUCKET_MACROS_SVH

// same-cycle implication, checked out of reset
`define NTH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define NTH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/nth_pkg.sv]
// types, constants and hash functions for the nibble table hash bucket block
`timescale 1ns / 1ps

package nth_pkg;

	localparam int HASH_W    = 32;
	localparam int OUT_W     = 31;
	localparam int BYTE_W    = 8;
	localparam int NIB_W     = 4;
	localparam int DIV_STEPS = OUT_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [ADDR_W-3:0] REG_BUCKET_COUNT   = 1'b0;
	localparam logic [OUT_W-1:0]  BUCKET_COUNT_RESET = 31'd1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_DONE = 3'b100
	} nth_state_t;

	typedef struct packed {
		logic fold;
		logic start;
		logic step;
		logic load_out;
	} nth_cmd_t;

	function automatic logic [HASH_W-1:0] nth_nib_word(input logic [NIB_W-1:0] idx);
		logic [HASH_W-1:0] w;
		unique case (idx)
			4'h0: w = 32'h00000000;
			4'h1: w = 32'hCC017601;
			4'h2: w = 32'hD8014C01;
			4'h3: w = 32'h14003A00;
			4'h4: w = 32'hF0013801;
			4'h5: w = 32'h3C004E00;
			4'h6: w = 32'h28007400;
			4'h7: w = 32'hE4010201;
			4'h8: w = 32'hA001D001;
			4'h9: w = 32'h6C00A600;
			4'hA: w = 32'h78009C00;
			4'hB: w = 32'hB401EA01;
			4'hC: w = 32'h5000E800;
			4'hD: w = 32'h9C019E01;
			4'hE: w = 32'h8801A401;
			4'hF: w = 32'h4400D200;
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [HASH_W-1:0] nth_fold(input logic [HASH_W-1:0] h,
			input logic [NIB_W-1:0] nib);
		return (h >> NIB_W) ^ nth_nib_word(h[NIB_W-1:0]) ^ nth_nib_word(nib);
	endfunction

endpackage

[design/nth_dp.sv]
// datapath: running hash, restoring remainder unit and result registers
`timescale 1ns / 1ps

module nth_dp
	import nth_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  nth_cmd_t          cmd,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [OUT_W-1:0]  bucket_count,
	output logic [OUT_W-1:0]  bucket,
	output logic [OUT_W-1:0]  hash_value
);

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] fold_lo;
	logic [HASH_W-1:0] fold_hi;
	logic [OUT_W-1:0]  hash_keep_q;
	logic [OUT_W-1:0]  dvd_q;
	logic [OUT_W-1:0]  div_q;
	logic [OUT_W-1:0]  rem_q;
	logic [OUT_W:0]    trial;
	logic [OUT_W+1:0]  diff;
	logic [OUT_W-1:0]  bucket_q;
	logic [OUT_W-1:0]  hash_value_q;

	// low nibble first, then high nibble
	assign fold_lo = nth_fold(hash_q, data_byte[NIB_W-1:0]);
	assign fold_hi = nth_fold(fold_lo, data_byte[BYTE_W-1:NIB_W]);

	// one quotient bit per cycle, only the remainder is kept
	assign trial = {rem_q, dvd_q[OUT_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (cmd.start) begin
			hash_q <= '0;
		end else if (cmd.fold) begin
			hash_q <= fold_hi;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hash_keep_q <= fold_hi[OUT_W-1:0];
			dvd_q       <= fold_hi[OUT_W-1:0];
			rem_q       <= '0;
			// a zero bucket count divides by one
			div_q       <= (bucket_count == '0) ? OUT_W'(1) : bucket_count;
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[OUT_W-2:0], 1'b0};
			rem_q <= diff[OUT_W+1] ? trial[OUT_W-1:0] : diff[OUT_W-1:0];
		end
		if (cmd.load_out) begin
			bucket_q     <= rem_q;
			hash_value_q <= hash_keep_q;
		end
	end

	assign bucket     = bucket_q;
	assign hash_value = hash_value_q;

endmodule

[design/nth_ctrl.sv]
// controller: byte acceptance, divider sequencing and result handoff
`timescale 1ns / 1ps
`include "nibble_table_hash_bucket_macros.svh"

module nth_ctrl
	import nth_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     last_byte,
	input  logic     out_ready,
	output logic     in_ready,
	output logic     out_valid,
	output nth_cmd_t cmd
);

	nth_state_t       state_q;
	nth_state_t       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;
	logic             slot_free;
	logic             div_last;

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign div_last  = (cnt_q == CNT_W'(DIV_STEPS - 1));

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.fold  = accept && !last_byte;
				cmd.start = accept && last_byte;
				if (accept && last_byte) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// wait for the output register to drain
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`NTH_ASSERT_NEXT(a_start_div, cmd.start, (state_q == S_DIV) && (cnt_q == '0),
		"last byte did not start the divider")
	`NTH_ASSERT_NEXT(a_div_len, (state_q == S_DIV) && div_last, state_q == S_DONE,
		"divider ran past its step count")
	`NTH_ASSERT_NOW(a_load_free, cmd.load_out, !out_valid_q || out_ready,
		"result loaded over a pending transaction")
	`NTH_ASSERT_NOW(a_rise_from_done, $rose(out_valid_q), $past(state_q == S_DONE),
		"result appeared without a finished division")

endmodule

[design/nibble_table_hash_bucket.sv]
// top level of the nibble table hash with modulo bucket selection
//
//  channel   signals                                   direction
//  input     in_valid / in_ready, data_byte, last_byte  in
//  output    out_valid / out_ready, bucket, hash_value  out
//  config    psel penable pwrite paddr pwdata prdata    apb, bucket_count at 0x0
//
// a byte without the last flag is folded into the running hash, both nibble steps together
// a last byte is folded, then runs 31 restoring remainder steps, then the result load
// the one-bit-per-cycle remainder unit sets the per-key cost
// a result still waiting on out_ready holds the next key in its load cycle, input stays blocked
// asynchronous reset clears the running hash and sets bucket_count to 1
`timescale 1ns / 1ps

module nibble_table_hash_bucket
	import nth_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OUT_W-1:0]  bucket,
	output logic [OUT_W-1:0]  hash_value,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	nth_cmd_t         cmd;
	logic [OUT_W-1:0] bucket_count_q;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1:2] == REG_BUCKET_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			bucket_count_q <= pwdata[OUT_W-1:0];
		end
	end

	assign prdata = reg_sel ? {{(DATA_W-OUT_W){1'b0}}, bucket_count_q} : '0;

	nth_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_byte (last_byte),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	nth_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.data_byte    (data_byte),
		.bucket_count (bucket_count_q),
		.bucket       (bucket),
		.hash_value   (hash_value)
	);

endmodule
